FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the random word generator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/crwg_pkg.sv
// ----------------------------------------------------------------------------
// crwg_pkg
// Constants, command/status types and mixing functions of the combined
// random word generator.
// ----------------------------------------------------------------------------
package crwg_pkg;

  // Field widths.
  localparam int WORD_W       = 64;
  localparam int SKIP_COUNT_W = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int WL_W         = 4;

  // Default for the skip count mask width.
  localparam int SKIP_BITS_DEFAULT = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_SIZE = 2'd1;

  // Word size code for full 64-bit words.
  localparam logic [1:0] WS_64 = 2'd3;

  // Generator constants.
  localparam logic [63:0] SEED_XOR = 64'd4101842887655102017;
  localparam logic [63:0] LCG_MUL  = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD  = 64'd7046029254386353087;
  localparam logic [31:0] MWC_MUL  = 32'd4294957665;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic init;
    logic step_mul;
    logic step_sum;
    logic copy_v;
    logic copy_w;
    logic shift_get;
    logic skip_sub;
    logic skip_div;
    logic cnt_dec;
    logic load;
    logic skip_tail;
    logic emit;
  } crwg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;
    logic z_zero;
    logic z_le_wl;
    logic can_shift;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } crwg_sts_t;

  // One step of the 17/31/8 xorshift.
  function automatic logic [63:0] xs_step(input logic [63:0] v);
    logic [63:0] t;
    t = v ^ (v >> 17);
    t = t ^ (t << 31);
    t = t ^ (t >> 8);
    return t;
  endfunction

  // Output value from the three sub-generator words.
  function automatic logic [63:0] mix(input logic [63:0] u, input logic [63:0] v,
                                      input logic [63:0] w);
    logic [63:0] x;
    x = u ^ (u << 21);
    x = x ^ (x >> 35);
    x = x ^ (x << 4);
    return (x + v) ^ w;
  endfunction

  // Mask of one output word for a word size code.
  function automatic logic [63:0] word_mask(input logic [1:0] ws);
    logic [63:0] m;
    case (ws)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

FILE: design/crwg_ifs.sv
// ----------------------------------------------------------------------------
// crwg_ifs
// Valid/ready channel interfaces for request items and result words.
// ----------------------------------------------------------------------------

// Request channel: get or skip.
interface crwg_in_if import crwg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [SKIP_COUNT_W-1:0] skip_count;

  modport source (output valid, output func, output skip_count, input ready);
  modport sink   (input valid, input func, input skip_count, output ready);
endinterface

// Result channel: one random word per get.
interface crwg_out_if import crwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

FILE: design/crwg_ctrl.sv
// ----------------------------------------------------------------------------
// crwg_ctrl
// Controller state machine: sequences seeding, get and skip operations
// as commands to the datapath.
// ----------------------------------------------------------------------------
module crwg_ctrl import crwg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      seed_wr,
  input  logic      in_valid,
  output logic      in_ready,
  input  crwg_sts_t sts,
  output crwg_cmd_t cmd
);

  typedef enum logic [15:0] {
    S_INIT      = 16'b0000_0000_0000_0001,
    S_SEED_MUL  = 16'b0000_0000_0000_0010,
    S_SEED_SUM  = 16'b0000_0000_0000_0100,
    S_SEED_COPY = 16'b0000_0000_0000_1000,
    S_IDLE      = 16'b0000_0000_0001_0000,
    S_DECIDE    = 16'b0000_0000_0010_0000,
    S_SKIP_SUB  = 16'b0000_0000_0100_0000,
    S_SKIP_DIV  = 16'b0000_0000_1000_0000,
    S_ADV_TEST  = 16'b0000_0001_0000_0000,
    S_ADV_MUL   = 16'b0000_0010_0000_0000,
    S_ADV_SUM   = 16'b0000_0100_0000_0000,
    S_GEN_MUL   = 16'b0000_1000_0000_0000,
    S_GEN_SUM   = 16'b0001_0000_0000_0000,
    S_LOAD      = 16'b0010_0000_0000_0000,
    S_SKIP_TAIL = 16'b0100_0000_0000_0000,
    S_EMIT      = 16'b1000_0000_0000_0000
  } crwg_state_t;

  // Seeding runs three steps; the first two are followed by a copy.
  localparam logic [1:0] PHASE_COPY_V = 2'd0;
  localparam logic [1:0] PHASE_LAST   = 2'd2;

  crwg_state_t state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        phase_nxt = PHASE_COPY_V;
        state_nxt = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_SEED_SUM;
      end
      S_SEED_SUM: begin
        cmd.step_sum = 1'b1;
        state_nxt    = (phase_r == PHASE_LAST) ? S_IDLE : S_SEED_COPY;
      end
      S_SEED_COPY: begin
        if (phase_r == PHASE_COPY_V) begin
          cmd.copy_v = 1'b1;
        end else begin
          cmd.copy_w = 1'b1;
        end
        phase_nxt = phase_r + 2'd1;
        state_nxt = S_SEED_MUL;
      end
      S_IDLE: begin
        in_ready = !seed_wr;
        if (in_valid && !seed_wr) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.func) begin
          if (sts.can_shift) begin
            cmd.shift_get = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.step_mul = 1'b1;
            state_nxt    = S_GEN_SUM;
          end
        end else if (sts.z_zero) begin
          state_nxt = S_IDLE;
        end else if (sts.z_le_wl) begin
          state_nxt = S_SKIP_TAIL;
        end else begin
          state_nxt = S_SKIP_SUB;
        end
      end
      S_SKIP_SUB: begin
        cmd.skip_sub = 1'b1;
        state_nxt    = S_SKIP_DIV;
      end
      S_SKIP_DIV: begin
        cmd.skip_div = 1'b1;
        state_nxt    = S_ADV_TEST;
      end
      S_ADV_TEST: begin
        state_nxt = sts.cnt_zero ? S_GEN_MUL : S_ADV_MUL;
      end
      S_ADV_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_ADV_SUM;
      end
      S_ADV_SUM: begin
        cmd.step_sum = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_nxt    = sts.cnt_one ? S_GEN_MUL : S_ADV_MUL;
      end
      S_GEN_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_GEN_SUM;
      end
      S_GEN_SUM: begin
        cmd.step_sum = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sts.func ? S_SKIP_TAIL : S_EMIT;
      end
      S_SKIP_TAIL: begin
        cmd.skip_tail = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
    // A seed write restarts the generator from any state.
    if (seed_wr) begin
      state_nxt = S_INIT;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      phase_r <= PHASE_COPY_V;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: design/crwg_dp.sv
// ----------------------------------------------------------------------------
// crwg_dp
// Datapath: sub-generator state, multiply/sum generator step, word buffer,
// skip arithmetic, configuration registers and the output register.
// ----------------------------------------------------------------------------
module crwg_dp import crwg_pkg::*; #(
  parameter int SKIP_BITS = SKIP_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  crwg_cmd_t               cmd,
  output crwg_sts_t               sts,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]       cfg_data,
  input  logic                    in_func,
  input  logic [SKIP_COUNT_W-1:0] in_skip_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WORD_W-1:0]       out_word
);

  // Stored skip count width: SKIP_BITS bits of the count, at most 32.
  localparam int ZW = (SKIP_BITS < SKIP_COUNT_W) ? SKIP_BITS : SKIP_COUNT_W;

  logic                   seed_wr, ws_wr;
  logic [WORD_W-1:0]      seed_r, seed_nxt;
  logic [1:0]             ws_r, ws_nxt;
  logic [WL_W-1:0]        wl_r, wl_nxt;
  logic [ZW-1:0]          cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      out_word_r, out_word_nxt;
  logic [63:0]            lcg_r, lcg_nxt;
  logic [63:0]            xs_r, xs_nxt;
  logic [63:0]            mwc_r, mwc_nxt;
  logic [63:0]            buf_r, buf_nxt;
  logic                   func_r, func_nxt;
  logic [ZW-1:0]          z_r, z_nxt;
  logic [63:0]            pp_ll_r, pp_ll_nxt;
  logic [31:0]            pp_lh_r, pp_lh_nxt;
  logic [31:0]            pp_hl_r, pp_hl_nxt;
  logic [63:0]            pp_mwc_r, pp_mwc_nxt;
  logic [63:0]            prod_lh, prod_hl;
  logic [SKIP_COUNT_W-1:0] z_ext, zm1, cnt_div, z_mod;
  logic [WL_W-1:0]        n_words;
  logic                   z_gt_n;
  logic [1:0]             div_sh;
  logic [6:0]             get_sh;
  logic [5:0]             tail_sh;
  logic [63:0]            lcg_step, mwc_step;

  assign seed_wr = cfg_we && (cfg_index == CFG_SEED);
  assign ws_wr   = cfg_we && (cfg_index == CFG_WORD_SIZE);

  // Word geometry and skip arithmetic.
  always_comb begin
    n_words = 4'd8 >> ws_r;
    z_ext   = SKIP_COUNT_W'(z_r);
    zm1     = z_ext - SKIP_COUNT_W'(1);
    z_gt_n  = z_ext > SKIP_COUNT_W'(n_words);
    div_sh  = 2'd3 - ws_r;
    cnt_div = zm1 >> div_sh;
    z_mod   = (zm1 & SKIP_COUNT_W'(n_words - 4'd1)) + SKIP_COUNT_W'(1);
    get_sh  = 7'd8 << ws_r;
    tail_sh = 6'({3'b000, zm1[2:0]} << (3'd3 + {1'b0, ws_r}));
  end

  // Partial products of the LCG multiply and the MWC product.
  always_comb begin
    prod_lh    = lcg_r[31:0] * LCG_MUL[63:32];
    prod_hl    = lcg_r[63:32] * LCG_MUL[31:0];
    pp_ll_nxt  = lcg_r[31:0] * LCG_MUL[31:0];
    pp_lh_nxt  = prod_lh[31:0];
    pp_hl_nxt  = prod_hl[31:0];
    pp_mwc_nxt = mwc_r[31:0] * MWC_MUL;
  end

  // Second half of a generator step: sum the partial products.
  always_comb begin
    lcg_step = pp_ll_r + {pp_lh_r + pp_hl_r, 32'h0} + LCG_ADD;
    mwc_step = pp_mwc_r + {32'h0, mwc_r[63:32]};
  end

  // Generator state updates.
  always_comb begin
    lcg_nxt = lcg_r;
    xs_nxt  = xs_r;
    mwc_nxt = mwc_r;
    if (cmd.init) begin
      lcg_nxt = seed_r ^ SEED_XOR;
      xs_nxt  = SEED_XOR;
      mwc_nxt = 64'd1;
    end else if (cmd.step_sum) begin
      lcg_nxt = lcg_step;
      xs_nxt  = xs_step(xs_r);
      mwc_nxt = mwc_step;
    end else if (cmd.copy_v) begin
      xs_nxt = lcg_r;
    end else if (cmd.copy_w) begin
      mwc_nxt = xs_r;
    end
  end

  // Word buffer and count of unread words.
  always_comb begin
    buf_nxt = buf_r;
    wl_nxt  = wl_r;
    if (ws_wr || cmd.init) begin
      buf_nxt = '0;
      wl_nxt  = '0;
    end else if (cmd.shift_get) begin
      buf_nxt = buf_r >> get_sh;
      wl_nxt  = wl_r - 4'd1;
    end else if (cmd.skip_sub) begin
      wl_nxt = '0;
    end else if (cmd.load) begin
      buf_nxt = mix(lcg_r, xs_r, mwc_r);
      wl_nxt  = func_r ? n_words : n_words - 4'd1;
    end else if (cmd.skip_tail) begin
      buf_nxt = buf_r >> tail_sh;
      wl_nxt  = wl_r - WL_W'(z_ext);
    end
  end

  // Latched request and skip bookkeeping.
  always_comb begin
    func_nxt = func_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    if (cmd.latch) begin
      func_nxt = in_func;
      z_nxt    = in_skip_count[ZW-1:0];
    end else if (cmd.skip_sub) begin
      z_nxt = ZW'(z_ext - SKIP_COUNT_W'(wl_r));
    end else if (cmd.skip_div) begin
      if (z_gt_n) begin
        z_nxt   = ZW'(z_mod);
        cnt_nxt = ZW'(cnt_div);
      end else begin
        cnt_nxt = '0;
      end
    end
    if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - ZW'(1);
    end
  end

  // Configuration registers and output register.
  always_comb begin
    seed_nxt      = seed_wr ? cfg_data : seed_r;
    ws_nxt        = ws_wr ? cfg_data[1:0] : ws_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = buf_r & word_mask(ws_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      ws_r        <= WS_64;
      wl_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      ws_r        <= ws_nxt;
      wl_r        <= wl_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lcg_r      <= lcg_nxt;
    xs_r       <= xs_nxt;
    mwc_r      <= mwc_nxt;
    buf_r      <= buf_nxt;
    func_r     <= func_nxt;
    z_r        <= z_nxt;
    out_word_r <= out_word_nxt;
    if (cmd.step_mul) begin
      pp_ll_r  <= pp_ll_nxt;
      pp_lh_r  <= pp_lh_nxt;
      pp_hl_r  <= pp_hl_nxt;
      pp_mwc_r <= pp_mwc_nxt;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.func      = func_r;
    sts.z_zero    = (z_r == '0);
    sts.z_le_wl   = (z_ext <= SKIP_COUNT_W'(wl_r));
    sts.can_shift = (wl_r != '0) && (ws_r != WS_64);
    sts.cnt_zero  = (cnt_r == '0);
    sts.cnt_one   = (cnt_r == ZW'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/combined_random_word_generator.sv
// ----------------------------------------------------------------------------
// combined_random_word_generator
// Combined LCG / xorshift / multiply-with-carry generator handing out
// 8, 16, 32 or 64-bit words of each 64-bit value, lowest first.
// Request channel in_ch: func 0 asks for the next word, func 1 discards
// skip_count words without a result. Result channel out_ch carries one
// zero-extended word per get. The cfg port writes the seed (index 0) and the
// word size (index 1); other indexes are ignored.
// A generator step registers the partial products of the split 64-bit LCG
// multiply, then sums them. A get shifts the buffered value in S_DECIDE or,
// if it needs a fresh value, runs a generator step and a load; either way
// its word is registered in S_EMIT. A zero skip ends in S_DECIDE, a skip
// within the buffered value passes through S_SKIP_TAIL, and one that runs
// past the buffer runs a generator step for each 64-bit value passed over
// and for the fresh value it loads. Reset and a seed write run the three
// warm-up steps with in_ch.ready low. The result sits in an output register,
// so a new request is taken while an earlier word waits; a stalled receiver
// holds that word and halts only the next get that reaches its emit point.
// ----------------------------------------------------------------------------
module combined_random_word_generator import crwg_pkg::*; #(
  parameter int SKIP_BITS = SKIP_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  crwg_in_if.sink                in_ch,
  crwg_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  crwg_cmd_t         cmd;
  crwg_sts_t         sts;
  logic              seed_wr;
  logic              in_ready;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;

  assign seed_wr = cfg_we && (cfg_index == CFG_SEED);

  // Sequencer.
  crwg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed_wr  (seed_wr),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Generator state and word handling.
  crwg_dp #(
    .SKIP_BITS (SKIP_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_func       (in_ch.func),
    .in_skip_count (in_ch.skip_count),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_word      (out_word)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.random_word = out_word;

endmodule

FILE: design/crwg_checker.sv
// ----------------------------------------------------------------------------
// crwg_checker
// Port-level checks of the random word generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crwg_checker import crwg_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [WORD_W-1:0]      out_word,
  input logic                   cfg_we,
  input logic [CFG_INDEX_W-1:0] cfg_index
);

  // Reset empties the output register.
  `ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid, "output valid after reset")

  // A seed write starts warm-up, which blocks new requests.
  `ASSERT_NEXT(a_seed_blocks_input, clk, rst_n, cfg_we && (cfg_index == CFG_SEED), !in_ready, "request taken during warm-up")

  // Requests are processed one at a time.
  `ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

  // A stalled result word is held.
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "stalled word changed")

endmodule

bind combined_random_word_generator crwg_checker u_crwg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.random_word),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

FILE: tb/combined_random_word_generator_test.sv
// ----------------------------------------------------------------------------
// combined_random_word_generator_test
// Self-checking bench for the combined random word generator. A scoreboard
// keeps its own copy of the LCG, xorshift and multiply-with-carry state,
// works out each word that a get should return and compares it with the
// words that arrive on the result channel. Directed gets and skips come
// first, then random phases that change the seed and the word size, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module combined_random_word_generator_test;
  import crwg_pkg::*;

  // Request codes and word size codes.
  localparam logic FUNC_GET  = 1'b0;
  localparam logic FUNC_SKIP = 1'b1;
  localparam logic [1:0] WS_8  = 2'd0;
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;

  // Register indexes that the block must ignore.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 40;

  // Scoreboard: mirrors the generator state and queues the words due.
  class word_scoreboard;
    logic [63:0] seed_reg;
    logic [1:0]  size_code;
    logic [63:0] lcg_state;
    logic [63:0] shift_state;
    logic [63:0] carry_state;
    logic [63:0] value_buf;
    int unsigned words_unread;
    logic [63:0] expected_words[$];
    int errors;
    int words_checked;
    int gets_seen;
    int skips_seen;
    int reg_writes;

    function new();
      seed_reg      = '0;
      size_code     = WS_64;
      errors        = 0;
      words_checked = 0;
      gets_seen     = 0;
      skips_seen    = 0;
      reg_writes    = 0;
      reseed();
    endfunction

    task report(input string what);
      if (errors < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    // Advance all three sub-generators by one step.
    function void step_all();
      logic [63:0] t;
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      t = shift_state ^ (shift_state >> 17);
      t = t ^ (t << 31);
      shift_state = t ^ (t >> 8);
      carry_state = {32'd0, MWC_MUL} * {32'd0, carry_state[31:0]} + (carry_state >> 32);
    endfunction

    // Step once and form the next 64-bit value.
    function logic [63:0] draw_value();
      logic [63:0] x;
      step_all();
      x = lcg_state ^ (lcg_state << 21);
      x = x ^ (x >> 35);
      x = x ^ (x << 4);
      return (x + shift_state) ^ carry_state;
    endfunction

    // Seeding with three warm-up steps; the buffered value is dropped.
    function void reseed();
      lcg_state   = seed_reg ^ SEED_XOR;
      shift_state = SEED_XOR;
      carry_state = 64'd1;
      step_all();
      shift_state = lcg_state;
      step_all();
      carry_state = shift_state;
      step_all();
      value_buf    = '0;
      words_unread = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
      reg_writes++;
      case (idx)
        CFG_SEED: begin
          seed_reg = data;
          reseed();
        end
        CFG_WORD_SIZE: begin
          size_code    = data[1:0];
          value_buf    = '0;
          words_unread = 0;
        end
        default: ;
      endcase
    endfunction

    // Note one accepted request and queue the word it should return.
    function void note_item(input logic func, input logic [SKIP_COUNT_W-1:0] count);
      int unsigned n_words;
      int unsigned bits;
      logic [63:0] mask;
      logic [63:0] z;
      logic [63:0] steps;
      logic [63:0] sh;
      n_words = 8 >> size_code;
      bits    = 8 << size_code;
      mask    = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      if (func == FUNC_GET) begin
        gets_seen++;
        if (words_unread > 0 && bits < 64) begin
          words_unread--;
          value_buf = value_buf >> bits;
        end else begin
          value_buf    = draw_value();
          words_unread = n_words - 1;
        end
        expected_words.push_back(value_buf & mask);
      end else begin
        skips_seen++;
        z = {32'd0, count};
        if (z > words_unread) begin
          z = z - words_unread;
          words_unread = 0;
          if (z > n_words) begin
            steps = (z - 1) / n_words;
            for (logic [63:0] k = 0; k < steps; k++) step_all();
            z = (z - 1) % n_words + 1;
          end
          value_buf    = draw_value();
          words_unread = n_words;
        end
        if (z != 0) begin
          // A skip inside the buffer shifts one word less than it charges.
          sh = (z - 1) * bits;
          if (sh < 64) value_buf = value_buf >> sh;
          words_unread -= int'(z);
        end
      end
    endfunction

    task check_word(input logic [63:0] got);
      logic [63:0] want;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h arrived with none due", got));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got !== want)
          report($sformatf("random_word %h, expected %h", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  crwg_in_if  in_ch ();
  crwg_out_if out_ch ();

  combined_random_word_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  word_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int tail_cycles;
  int cycle_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check each accepted word and stall in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) board.check_word(out_ch.random_word);
      if (stall_left > 0) stall_left--;
      else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
        stall_left = $urandom_range(1, 15);
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Offer one request, wait for it to be taken, then maybe idle a while.
  task automatic send_item(input logic func, input logic [SKIP_COUNT_W-1:0] count);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.skip_count <= count;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(func, count);
    tail_cycles = (func == FUNC_SKIP) ? 20 + 2 * (count / (8 >> board.size_code) + 2) : 20;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Let every due word arrive, then give a trailing skip time to finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.expected_words.size() != 0);
    repeat (tail_cycles) @(posedge clk);
  endtask

  // One register write; cfg_we is then held low before the task returns.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Inverse of x ^= x >> s and of x ^= x << s, by fixed-point iteration.
  function automatic logic [63:0] undo_right(input logic [63:0] y, input int s);
    logic [63:0] x;
    x = y;
    repeat (64 / s + 1) x = y ^ (x >> s);
    return x;
  endfunction

  function automatic logic [63:0] undo_left(input logic [63:0] y, input int s);
    logic [63:0] x;
    x = y;
    repeat (64 / s + 1) x = y ^ (x << s);
    return x;
  endfunction

  // Seed whose warm-up leaves the multiply-with-carry word at its fixed
  // point, so the carry generator stays stuck for the whole phase.
  function automatic logic [63:0] stuck_carry_seed();
    logic [63:0] fixed_point;
    logic [63:0] lcg_inv;
    logic [63:0] v;
    fixed_point = ({32'd0, MWC_MUL} << 32) - 64'd1;
    lcg_inv = LCG_MUL;
    repeat (6) lcg_inv = lcg_inv * (64'd2 - LCG_MUL * lcg_inv);
    v = undo_right(undo_left(undo_right(fixed_point, 8), 31), 17);
    return SEED_XOR ^ ((v - LCG_ADD) * lcg_inv);
  endfunction

  // Random requests: mostly gets, skips mostly short with a few long ones.
  task automatic random_items(input int count);
    int unsigned n_words;
    int unsigned pick;
    logic [SKIP_COUNT_W-1:0] skip_len;
    for (int i = 0; i < count; i++) begin
      n_words = 8 >> board.size_code;
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_item(FUNC_GET, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)      skip_len = $urandom_range(0, n_words + 1);
        else if (pick < 80) skip_len = $urandom_range(0, 4 * n_words);
        else if (pick < 96) skip_len = $urandom_range(0, 64);
        else                skip_len = $urandom_range(65, 600);
        send_item(FUNC_SKIP, skip_len);
      end
    end
  endtask

  initial begin
    logic [63:0] seed;
    board            = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SEED;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_GET;
    in_ch.skip_count = '0;
    out_ch.ready     = 1'b1;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    tail_cycles      = 20;
    cycle_count      = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (20) @(posedge clk);

    // Reset seed, 64-bit words: zero, single and all-ones counts.
    send_item(FUNC_GET, '0);
    send_item(FUNC_GET, '1);
    send_item(FUNC_SKIP, 32'd0);
    send_item(FUNC_SKIP, 32'd1);
    send_item(FUNC_GET, '0);
    send_item(FUNC_SKIP, 32'd2);
    send_item(FUNC_GET, '0);

    // Byte words: skip within the buffer, drain it, then a skip to its end and one across values.
    settle();
    write_reg(CFG_WORD_SIZE, {62'd0, WS_8});
    send_item(FUNC_GET, '0);
    send_item(FUNC_GET, '0);
    send_item(FUNC_SKIP, 32'd2);
    repeat (5) send_item(FUNC_GET, '0);
    send_item(FUNC_SKIP, 32'd7);
    send_item(FUNC_SKIP, 32'd17);
    send_item(FUNC_GET, '0);

    // All-ones seed with 16-bit words.
    settle();
    write_reg(CFG_SEED, '1);
    write_reg(CFG_WORD_SIZE, {62'd0, WS_16});
    send_item(FUNC_SKIP, 32'd5);
    send_item(FUNC_GET, '0);
    send_item(FUNC_GET, '0);

    // Unused indexes are ignored; stuck carry word with 32-bit words.
    settle();
    write_reg(CFG_SPARE_2, {$urandom, $urandom});
    write_reg(CFG_SPARE_3, {$urandom, $urandom});
    write_reg(CFG_SEED, stuck_carry_seed());
    write_reg(CFG_WORD_SIZE, {62'd0, WS_32});
    repeat (3) send_item(FUNC_GET, '0);

    // Random phases; the last two run without any idling.
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      if (ph < 10) begin
        send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
        recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph % 3 != 2) begin
        case (ph)
          0:       seed = '0;
          1:       seed = '1;
          5:       seed = stuck_carry_seed();
          default: seed = {$urandom, $urandom};
        endcase
        write_reg(CFG_SEED, seed);
      end
      if ($urandom_range(4) == 0)
        write_reg(($urandom_range(1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                  {$urandom, $urandom});
      write_reg(CFG_WORD_SIZE, {$urandom, 30'($urandom), 2'(ph % 4)});
      random_items(140);
    end

    settle();
    $display("Covered %0d gets and %0d skips over %0d register writes; %0d words checked.",
             board.gets_seen, board.skips_seen, board.reg_writes, board.words_checked);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d words still due", board.errors,
               board.expected_words.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: combined_random_word_generator.f
+incdir+design
design/crwg_pkg.sv
design/crwg_ifs.sv
design/crwg_ctrl.sv
design/crwg_dp.sv
design/combined_random_word_generator.sv
design/crwg_checker.sv
tb/combined_random_word_generator_test.sv
